// ----- src/sel_pkg.sv -----
// shared types, constants and register codes for the sphere edge-length field
// used by every module under src; depends on nothing
`default_nettype none

package sel_pkg;

    // field widths of the stream payload
    localparam int SEL_FIELD_W    = 32;               // one point or centre coordinate
    localparam int SEL_LEN_W      = 31;               // radius, lengths, root
    localparam int SEL_SUM_W      = 2 * SEL_LEN_W;    // squared distance while inside
    localparam int SEL_ACC_W      = SEL_SUM_W + 2;    // sum of three squares
    localparam int SEL_COORD_WIDTH = 32;              // width at which coordinates are read

    // configuration port
    localparam int SEL_CFG_AW = 3;
    localparam int SEL_CFG_DW = 32;

    localparam logic [SEL_FIELD_W-1:0] SEL_CENTRE_RST = '0;
    localparam logic [SEL_LEN_W-1:0]   SEL_RADIUS_RST = SEL_LEN_W'(65536);
    localparam logic [SEL_LEN_W-1:0]   SEL_LENGTH_RST = SEL_LEN_W'(65536);

    typedef enum logic [SEL_CFG_AW-1:0] {
        REG_CENTRE_X     = 3'd0,
        REG_CENTRE_Y     = 3'd1,
        REG_CENTRE_Z     = 3'd2,
        REG_RADIUS       = 3'd3,
        REG_LENGTH_INNER = 3'd4,
        REG_LENGTH_OUTER = 3'd5
    } t_cfg_reg;

    // control bits that travel with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic outside;
    } t_side;

endpackage

`default_nettype wire

// ----- src/sel_dist.sv -----
// distance front end: axis differences, magnitudes, squares, sum and radius test
// five register stages; depends on sel_pkg
`default_nettype none

module sel_dist
    import sel_pkg::*;
#(
    parameter int COORD_WIDTH = SEL_COORD_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [SEL_FIELD_W-1:0] i_point [3],
    input  wire logic [SEL_FIELD_W-1:0] i_centre [3],
    input  wire logic [SEL_LEN_W-1:0]   i_radius,
    output t_side                       o_side,
    output logic      [SEL_SUM_W-1:0]   o_sum
);

    // coordinates wider than the field read as unsigned field values
    localparam int XW = (COORD_WIDTH > SEL_FIELD_W) ? SEL_FIELD_W + 1 : COORD_WIDTH;
    localparam int DW = XW + 1;
    localparam int MW = (DW > SEL_LEN_W) ? DW : SEL_LEN_W;

    function automatic logic [XW-1:0] f_ext(input logic [SEL_FIELD_W-1:0] v);
        return XW'({1'b0, v});
    endfunction

    logic signed [DW-1:0]        r_d   [3];
    logic        [SEL_LEN_W-1:0] r_mag [3];
    logic        [SEL_SUM_W-1:0] r_sq  [3];
    logic        [SEL_ACC_W-1:0] r_acc;
    logic        [SEL_SUM_W-1:0] r_r2;
    logic        [SEL_SUM_W-1:0] r_sum;
    t_side                       r_side [5];

    logic signed [DW-1:0]        n_d   [3];
    logic        [SEL_LEN_W-1:0] n_mag [3];
    logic                        n_over;
    logic                        n_outside;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [XW-1:0] p;
            logic [XW-1:0] c;
            p = f_ext(i_point[i]);
            c = f_ext(i_centre[i]);
            n_d[i] = $signed({p[XW-1], p}) - $signed({c[XW-1], c});
        end
    end

    always_comb begin
        n_over = 1'b0;
        for (int i = 0; i < 3; i++) begin
            logic [DW-1:0] m;
            logic [MW-1:0] mx;
            m  = r_d[i][DW-1] ? DW'(-r_d[i]) : DW'(r_d[i]);
            mx = MW'(m);
            n_mag[i] = mx[SEL_LEN_W-1:0];
            if (mx > MW'(i_radius)) begin
                n_over = 1'b1;
            end
        end
    end

    assign n_outside = r_side[3].outside || (r_acc > SEL_ACC_W'(r_r2));

    // r_r2 follows the radius; user must change it only while idle, unenforced
    always_ff @(posedge i_clk) begin
        r_r2 <= SEL_SUM_W'(i_radius) * SEL_SUM_W'(i_radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 5; s++) begin
                r_side[s] <= '0;
            end
        end else if (i_en) begin
            r_side[0] <= '{valid: i_valid, outside: 1'b0};
            r_side[1] <= '{valid: r_side[0].valid, outside: n_over};
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_side[4] <= '{valid: r_side[3].valid, outside: n_outside};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i]   <= n_d[i];
                r_mag[i] <= n_mag[i];
                r_sq[i]  <= SEL_SUM_W'(r_mag[i]) * SEL_SUM_W'(r_mag[i]);
            end
            r_acc <= SEL_ACC_W'(r_sq[0]) + SEL_ACC_W'(r_sq[1]) + SEL_ACC_W'(r_sq[2]);
            // an outside item carries zero so the root stage sees a small value
            r_sum <= n_outside ? '0 : r_acc[SEL_SUM_W-1:0];
        end
    end

    assign o_side = r_side[4];
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

// ----- src/sel_sqrt.sv -----
// pipelined integer square root, one root bit per register stage
// depends on sel_pkg
`default_nettype none

module sel_sqrt
    import sel_pkg::*;
#(
    parameter int QW = SEL_LEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_side            i_side,
    input  wire logic [2*QW-1:0]  i_sum,
    output t_side                 o_side,
    output logic      [QW-1:0]    o_root
);

    localparam int RW = 2 * QW;

    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_root [QW];
    t_side         r_side [QW];

    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int K = QW - 1 - s;

        logic [RW-1:0] w_rem_in;
        logic [QW-1:0] w_root_in;
        t_side         w_side_in;
        logic [RW-1:0] w_trial;
        logic          w_ge;
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_root;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_sum;
            assign w_root_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_side_in = r_side[s-1];
        end

        // (root + 2^k)^2 - root^2 with root holding only bits above k
        assign w_trial = (RW'(w_root_in) << (K + 1)) | (RW'(1) << (2 * K));
        assign w_ge    = (w_rem_in >= w_trial);
        assign n_rem   = w_ge ? (w_rem_in - w_trial) : w_rem_in;
        assign n_root  = w_root_in | (QW'(w_ge) << K);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else if (i_en) begin
                r_side[s] <= w_side_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_side = r_side[QW-1];
    assign o_root = r_root[QW-1];

    // outside items enter with a zero sum, so their root must come out zero
    a_outside_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_side[QW-1].valid && r_side[QW-1].outside) |-> (r_root[QW-1] == '0))
        else $error("sel_sqrt: outside item with non-zero root");

endmodule

`default_nettype wire

// ----- src/sel_div.sv -----
// pipelined restoring divider, one quotient bit per register stage
// quotient must fit QW bits; depends on sel_pkg
`default_nettype none

module sel_div
    import sel_pkg::*;
#(
    parameter int QW = SEL_LEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire t_side            i_side,
    input  wire logic [2*QW-1:0]  i_num,
    input  wire logic [QW-1:0]    i_den,
    output t_side                 o_side,
    output logic      [QW-1:0]    o_quot
);

    logic [QW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [QW-1:0] r_quot [QW];
    t_side         r_side [QW];

    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int K = QW - 1 - s;

        logic [QW-1:0] w_rem_in;
        logic [QW-1:0] w_low_in;
        logic [QW-1:0] w_quot_in;
        t_side         w_side_in;
        logic [QW:0]   w_sh;
        logic [QW:0]   w_diff;
        logic          w_ge;
        logic [QW-1:0] n_rem;
        logic [QW-1:0] n_quot;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_num[2*QW-1:QW];
            assign w_low_in  = i_num[QW-1:0];
            assign w_quot_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_low_in  = r_low[s-1];
            assign w_quot_in = r_quot[s-1];
            assign w_side_in = r_side[s-1];
        end

        assign w_sh   = {w_rem_in, w_low_in[K]};
        assign w_diff = w_sh - {1'b0, i_den};
        assign w_ge   = (w_sh >= {1'b0, i_den});
        assign n_rem  = w_ge ? w_diff[QW-1:0] : w_sh[QW-1:0];
        assign n_quot = w_quot_in | (QW'(w_ge) << K);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else if (i_en) begin
                r_side[s] <= w_side_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_low[s]  <= w_low_in;
                r_quot[s] <= n_quot;
            end
        end
    end

    assign o_side = r_side[QW-1];
    assign o_quot = r_quot[QW-1];

endmodule

`default_nettype wire

// ----- src/sel_skid.sv -----
// output register with a skid stage; upstream ready is a register
// depends on sel_pkg
`default_nettype none

module sel_skid
    import sel_pkg::*;
#(
    parameter int W = SEL_LEN_W + 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic      [W-1:0] o_data,
    input  wire logic         i_ready
);

    logic         r_out_valid;
    logic [W-1:0] r_out_data;
    logic         r_sk_valid;
    logic [W-1:0] r_sk_data;
    logic         w_push;

    assign w_push = i_valid && !r_sk_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out_data <= r_sk_valid ? r_sk_data : i_data;
        end else if (w_push) begin
            r_sk_data <= i_data;
        end
    end

    assign o_ready = !r_sk_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("sel_skid: skid holds a request while the output is empty");

    a_stalled_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_out_valid && !i_ready) |=> r_sk_valid)
        else $error("sel_skid: request pushed into a stalled output was dropped");

endmodule

`default_nettype wire

// ----- src/sphere_edge_length_field.sv -----
// top level of the sphere edge-length field: configuration, interpolation, output
// depends on sel_pkg, sel_dist, sel_sqrt, sel_div and sel_skid
`default_nettype none

// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tdata: point_x, point_y, point_z
// m_axis    out        m_axis_tvalid/tready      tdata: edge_length; tuser: outside
// cfg       in         i_cfg_wen (no wait)       i_cfg_addr, i_cfg_wdata
//
// one request accepted per cycle while the skid stage is empty
// the path runs through 5 distance stages, 31 root stages, 1 multiply,
// 31 divide stages, 1 length stage and the output register
// the whole pipeline moves on one enable, the registered ready of the skid stage
// reset is synchronous and active low; it clears all valid bits and resets the configuration registers
// a stalled output parks one request in the skid stage, then ready drops

module sphere_edge_length_field
    import sel_pkg::*;
#(
    parameter int COORD_WIDTH = SEL_COORD_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [3*SEL_FIELD_W-1:0] s_axis_tdata,   // point_x, point_y, point_z

    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic      [SEL_FIELD_W-1:0]   m_axis_tdata,   // edge_length, zero pad bit
    output logic                          m_axis_tuser,   // outside

    input  wire logic                     i_cfg_wen,
    input  wire logic [SEL_CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [SEL_CFG_DW-1:0]    i_cfg_wdata
);

    // configuration registers
    logic [SEL_FIELD_W-1:0] r_centre [3];
    logic [SEL_LEN_W-1:0]   r_radius;
    logic [SEL_LEN_W-1:0]   r_len_in;
    logic [SEL_LEN_W-1:0]   r_len_out;

    // interpolation slope magnitude and direction, derived from the registers
    logic [SEL_LEN_W-1:0]   r_delta;
    logic                   r_dir_up;

    logic                   w_en;
    logic [SEL_FIELD_W-1:0] w_point [3];

    t_side                  w_dist_side;
    logic [SEL_SUM_W-1:0]   w_sum;
    t_side                  w_root_side;
    logic [SEL_LEN_W-1:0]   w_root;

    t_side                  r_mul_side;
    logic [SEL_SUM_W-1:0]   r_prod;

    t_side                  w_div_side;
    logic [SEL_LEN_W-1:0]   w_quot;

    t_side                  r_fin_side;
    logic [SEL_LEN_W-1:0]   r_fin_len;
    logic [SEL_LEN_W-1:0]   n_term;
    logic [SEL_LEN_W-1:0]   n_len;

    logic [SEL_LEN_W:0]     w_out_data;

    // the user must send register writes only while the pipeline is empty; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre[0] <= SEL_CENTRE_RST;
            r_centre[1] <= SEL_CENTRE_RST;
            r_centre[2] <= SEL_CENTRE_RST;
            r_radius    <= SEL_RADIUS_RST;
            r_len_in    <= SEL_LENGTH_RST;
            r_len_out   <= SEL_LENGTH_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                REG_CENTRE_X:     r_centre[0] <= i_cfg_wdata;
                REG_CENTRE_Y:     r_centre[1] <= i_cfg_wdata;
                REG_CENTRE_Z:     r_centre[2] <= i_cfg_wdata;
                REG_RADIUS:       r_radius    <= i_cfg_wdata[SEL_LEN_W-1:0];
                REG_LENGTH_INNER: r_len_in    <= i_cfg_wdata[SEL_LEN_W-1:0];
                REG_LENGTH_OUTER: r_len_out   <= i_cfg_wdata[SEL_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // slope is registered from the length registers, long before any request needs it
    always_ff @(posedge i_clk) begin
        r_dir_up <= (r_len_out >= r_len_in);
        r_delta  <= (r_len_out >= r_len_in) ? (r_len_out - r_len_in) : (r_len_in - r_len_out);
    end

    assign w_point[0] = s_axis_tdata[SEL_FIELD_W-1:0];
    assign w_point[1] = s_axis_tdata[2*SEL_FIELD_W-1:SEL_FIELD_W];
    assign w_point[2] = s_axis_tdata[3*SEL_FIELD_W-1:2*SEL_FIELD_W];

    assign s_axis_tready = w_en;

    // squared distance and the exact outside test
    sel_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_axis_tvalid),
        .i_point  (w_point),
        .i_centre (r_centre),
        .i_radius (r_radius),
        .o_side   (w_dist_side),
        .o_sum    (w_sum)
    );

    // r = floor(sqrt(sum)), never above the radius for an inside point
    sel_sqrt #(
        .QW (SEL_LEN_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_dist_side),
        .i_sum   (w_sum),
        .o_side  (w_root_side),
        .o_root  (w_root)
    );

    // r times the length difference, exact
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_side <= '0;
        end else if (w_en) begin
            r_mul_side <= w_root_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= SEL_SUM_W'(w_root) * SEL_SUM_W'(r_delta);
        end
    end

    // quotient by the radius truncates toward zero and, for a non-zero radius, never exceeds the difference
    sel_div #(
        .QW (SEL_LEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (r_mul_side),
        .i_num   (r_prod),
        .i_den   (r_radius),
        .o_side  (w_div_side),
        .o_quot  (w_quot)
    );

    // zero radius: only the centre itself is inside, and it takes the inner length
    always_comb begin
        n_term = (r_radius == '0) ? '0 : w_quot;
        if (w_div_side.outside) begin
            n_len = '0;
        end else if (r_dir_up) begin
            n_len = r_len_in + n_term;
        end else begin
            n_len = r_len_in - n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_side <= '0;
        end else if (w_en) begin
            r_fin_side <= w_div_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin_len <= n_len;
        end
    end

    // output register and skid stage part the two sides
    sel_skid #(
        .W (SEL_LEN_W + 1)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fin_side.valid),
        .i_data  ({r_fin_side.outside, r_fin_len}),
        .o_ready (w_en),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, w_out_data[SEL_LEN_W-1:0]};
    assign m_axis_tuser = w_out_data[SEL_LEN_W];

    a_outside_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("sel: outside request with non-zero edge length");

    a_stall_holds_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_fin_len) && $stable(r_fin_side)))
        else $error("sel: last pipeline stage moved while stalled");

endmodule

`default_nettype wire
